// ----- src/geth_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// geth_pkg - shared definitions for the gated event-type histogram
// Defaults, configuration register indexes and the cell control bundle.
// ----------------------------------------------------------------------------
package geth_pkg;

    // Defaults for the top-level parameters
    localparam int NUM_TYPES_DEF   = 64;
    localparam int COUNT_WIDTH_DEF = 32;

    // Configuration port shape
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 64;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_TYPE_MASK     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_TICK_INTERVAL = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_START_TYPE    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_STOP_TYPE     = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_TICK_TYPE_A   = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_TICK_TYPE_B   = 3'd5;

    // Per-cell control: rotate the chain by one, or bump this cell's count
    typedef struct packed {
        logic shift;
        logic inc;
    } cell_ctl_t;

endpackage

// ----- src/geth_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// geth_cell - one counter cell of the histogram chain
// Holds one saturating count; takes its neighbor's count when the chain shifts.
// ----------------------------------------------------------------------------
module geth_cell
    import geth_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  cell_ctl_t              ctl,
    input  logic [COUNT_WIDTH-1:0] shift_in,
    output logic [COUNT_WIDTH-1:0] count
);

    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] count_next;

    // Shift from the neighbor, or increment and hold at full scale
    always_comb begin
        count_next = count_reg;
        if (ctl.shift) begin
            count_next = shift_in;
        end else if (ctl.inc && !(&count_reg)) begin
            count_next = count_reg + COUNT_WIDTH'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    assign count = count_reg;

endmodule

// ----- src/gated_event_type_histogram_top.sv -----
`timescale 1ns / 1ps
// Dump: a flush or tick transfer enters the dump state; each masked type's count
//   is registered into the output as it reaches the head, held by any output stall.
// Throughput: one event record per cycle while idle; a dump holds off the input
//   for one full rotation of the counter chain, lengthened by any output stall.
// Reset: synchronous active-low aresetn clears all counters, the gate phase,
//   the tick count and the registers to their defaults at once; no clearing pass.
// ----------------------------------------------------------------------------
// gated_event_type_histogram_top - gated per-type event histogram
// Gates an event stream by start/stop types, counts masked types in a chain of
// counter cells and dumps the counts on each tick interval or on a flush.
// ----------------------------------------------------------------------------
module gated_event_type_histogram_top
    import geth_pkg::*;
#(
    parameter int NUM_TYPES   = NUM_TYPES_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration writes
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // Input channel
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [5:0] event_type, [7:6] zero
    input  logic                  s_tuser,   // [0] action (1 = flush)
    // Result channel
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [39:0]           m_tdata,   // [5:0] type_index, [37:6] type_count
    output logic                  m_tlast    // last_of_group
);

    localparam int IDX_W = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
    localparam logic [IDX_W-1:0] POS_LAST = IDX_W'(NUM_TYPES - 1);
    localparam logic [63:0] RANGE_MASK =
        (NUM_TYPES >= 64) ? {64{1'b1}} : ((64'd1 << NUM_TYPES) - 64'd1);
    localparam logic [6:0] NUM_TYPES_7 = 7'(NUM_TYPES);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_DUMP = 1'b1;

    localparam logic [1:0] PH_INIT   = 2'd0;
    localparam logic [1:0] PH_OPEN   = 2'd1;
    localparam logic [1:0] PH_CLOSED = 2'd2;

    // Configuration registers
    logic [63:0] type_mask_reg;
    logic [15:0] tick_interval_reg;
    logic [6:0]  start_type_reg;
    logic [6:0]  stop_type_reg;
    logic [5:0]  tick_type_a_reg;
    logic [5:0]  tick_type_b_reg;

    // Control state
    logic             state_reg, state_next;
    logic [1:0]       phase_reg, phase_next;
    logic [15:0]      tick_reg, tick_next;
    logic [IDX_W-1:0] pos_reg, pos_next;

    // Output register
    logic        m_valid_reg, m_valid_next;
    logic [5:0]  m_index_reg, m_index_next;
    logic [31:0] m_count_reg, m_count_next;
    logic        m_last_reg, m_last_next;

    // Chain signals
    logic [COUNT_WIDTH-1:0] cnt [NUM_TYPES];
    cell_ctl_t              ctl [NUM_TYPES];
    logic [COUNT_WIDTH-1:0] ret_val;
    logic [31:0]            head_sat;

    logic        in_xfer;
    logic        action;
    logic [5:0]  ev_type;
    logic        start_valid, stop_valid, open, in_range;
    logic        inc_en;
    logic        out_free;
    logic        mask_hit;
    logic        step;
    logic [63:0] mask_vis;
    logic        is_last;
    logic [16:0] tick_inc;

    assign in_xfer = s_tvalid && s_tready;
    assign action  = s_tuser;
    assign ev_type = s_tdata[5:0];

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            type_mask_reg     <= {64{1'b1}};
            tick_interval_reg <= 16'd1;
            start_type_reg    <= 7'd64;
            stop_type_reg     <= 7'd64;
            tick_type_a_reg   <= 6'd0;
            tick_type_b_reg   <= 6'd1;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_TYPE_MASK:     type_mask_reg     <= cfg_wdata;
                REG_TICK_INTERVAL: tick_interval_reg <= cfg_wdata[15:0];
                REG_START_TYPE:    start_type_reg    <= cfg_wdata[6:0];
                REG_STOP_TYPE:     stop_type_reg     <= cfg_wdata[6:0];
                REG_TICK_TYPE_A:   tick_type_a_reg   <= cfg_wdata[5:0];
                REG_TICK_TYPE_B:   tick_type_b_reg   <= cfg_wdata[5:0];
                default: ;
            endcase
        end
    end

    // Saturate the head cell's count to the 32-bit result field
    generate
        if (COUNT_WIDTH > 32) begin : g_sat_wide
            assign head_sat = (|cnt[0][COUNT_WIDTH-1:32]) ? {32{1'b1}} : cnt[0][31:0];
        end else begin : g_sat_narrow
            assign head_sat = 32'(cnt[0]);
        end
    endgenerate

    // Gate and dump decisions
    assign start_valid = start_type_reg < NUM_TYPES_7;
    assign stop_valid  = stop_type_reg < NUM_TYPES_7;
    assign in_range    = {1'b0, ev_type} < NUM_TYPES_7;
    assign open        = (phase_reg == PH_OPEN) || ((phase_reg == PH_INIT) && !start_valid);
    assign tick_inc    = {1'b0, tick_reg} + 17'd1;
    assign out_free    = !m_valid_reg || m_tready;
    assign mask_hit    = type_mask_reg[pos_reg];
    assign step        = (state_reg == ST_DUMP) && (!mask_hit || out_free);
    assign mask_vis    = (type_mask_reg & RANGE_MASK) >> pos_reg;
    assign is_last     = (mask_vis[63:1] == 63'd0);
    assign ret_val     = mask_hit ? '0 : cnt[0];

    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        tick_next  = tick_reg;
        pos_next   = pos_reg;
        inc_en     = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    if (action) begin
                        state_next = ST_DUMP;
                    end else if (open || (start_valid && ev_type == start_type_reg[5:0])) begin
                        if (!open) begin
                            phase_next = PH_OPEN;
                        end
                        if (stop_valid && ev_type == stop_type_reg[5:0]) begin
                            phase_next = PH_CLOSED;
                        end else if (ev_type == tick_type_a_reg
                                     || ev_type == tick_type_b_reg) begin
                            if (tick_inc >= {1'b0, tick_interval_reg}) begin
                                tick_next  = 16'd0;
                                state_next = ST_DUMP;
                            end else begin
                                tick_next = tick_inc[15:0];
                            end
                        end else if (in_range && type_mask_reg[ev_type]) begin
                            inc_en = 1'b1;
                        end
                    end
                end
            end
            ST_DUMP: begin
                // Rotate the chain one cell per step until every type passed the head
                if (step) begin
                    if (pos_reg == POS_LAST) begin
                        pos_next   = '0;
                        state_next = ST_IDLE;
                    end else begin
                        pos_next = pos_reg + IDX_W'(1);
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Load the output register from the head cell on a masked step
    always_comb begin
        m_valid_next = m_valid_reg;
        m_index_next = m_index_reg;
        m_count_next = m_count_reg;
        m_last_next  = m_last_reg;
        if (m_tready) begin
            m_valid_next = 1'b0;
        end
        if (step && mask_hit) begin
            m_valid_next = 1'b1;
            m_index_next = 6'(pos_reg);
            m_count_next = head_sat;
            m_last_next  = is_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            phase_reg   <= PH_INIT;
            tick_reg    <= '0;
            pos_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            tick_reg    <= tick_next;
            pos_reg     <= pos_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_index_reg <= m_index_next;
        m_count_reg <= m_count_next;
        m_last_reg  <= m_last_next;
    end

    // Counter chain: cell i hands its count to cell i-1; the head wraps to the tail, cleared once reported
    generate
        for (genvar i = 0; i < NUM_TYPES; i++) begin : g_cell
            logic [COUNT_WIDTH-1:0] nb_in;
            if (i == NUM_TYPES - 1) begin : g_tail
                assign nb_in = ret_val;
            end else begin : g_body
                assign nb_in = cnt[i+1];
            end
            assign ctl[i].shift = step;
            assign ctl[i].inc   = inc_en && (ev_type == 6'(i));
            geth_cell #(
                .COUNT_WIDTH (COUNT_WIDTH)
            ) u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .ctl      (ctl[i]),
                .shift_in (nb_in),
                .count    (cnt[i])
            );
        end
    endgenerate

    // Ports
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_count_reg, m_index_reg};
    assign m_tlast  = m_last_reg;

    // Checks
    a_flush_dumps: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser) |=> (state_reg == ST_DUMP))
        else $error("flush transfer did not start a dump");

    a_result_from_dump: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_DUMP))
        else $error("result appeared outside a dump");

    a_chain_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (pos_reg == '0))
        else $error("chain left rotated after a dump");

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= POS_LAST)
        else $error("dump position out of range");

    a_no_shift_with_inc: assert property (@(posedge aclk) disable iff (!aresetn)
        step |-> !inc_en)
        else $error("count increment during chain rotation");

endmodule
